[rtl/core/gsa_pkg.sv]
package gsa_pkg;

  // Map geometry and kernel size
  localparam int MAP_SIDE      = 160;
  localparam int CODEWORDS     = 16;
  localparam int SIGMA         = 10;
  localparam int RADIUS_MULT   = 3;
  localparam int RADIUS        = RADIUS_MULT * SIGMA;
  localparam int WIN           = 2 * RADIUS + 1;
  localparam int CELLS_PER_MAP = MAP_SIDE * MAP_SIDE;
  localparam int TOTAL_CELLS   = CODEWORDS * CELLS_PER_MAP;
  localparam int ROW_STEP      = MAP_SIDE - WIN + 1;

  // Field and datapath widths
  localparam int CMD_W   = 2;
  localparam int CW_W    = 4;
  localparam int OFS_W   = 8;
  localparam int WGT_W   = 24;
  localparam int ACC_W   = 32;
  localparam int G_W     = 17;
  localparam int PROD_W  = WGT_W + G_W;
  localparam int ADDR_W  = $clog2(TOTAL_CELLS);
  localparam int SADDR_W = ADDR_W + 2;
  localparam int COORD_W = $clog2(MAP_SIDE + 2 * RADIUS + 256) + 1;
  localparam int CNT_W   = $clog2(WIN);
  localparam int GIDX_W  = $clog2(RADIUS + 1);

  // Saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [CW_W-1:0]         codeword;
    logic signed [OFS_W-1:0] x_offset;
    logic signed [OFS_W-1:0] y_offset;
    logic [WGT_W-1:0]        weight;
  } gsa_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] cell_value;
    logic                    in_bounds;
  } gsa_out_t;

  // Sequencer to multiply/accumulate unit
  typedef struct packed {
    logic load_a;    // weight * G(dx) into first product register
    logic load_amt;  // first product * G(dy) into cell amount register
    logic sub;       // subtract the amount rather than add it
  } gsa_mac_ctrl_t;

  // Gaussian kernel, G(d) in unsigned Q1.16, sigma 10
  function automatic logic [G_W-1:0] gauss_lut(input logic [GIDX_W-1:0] d);
    logic [G_W-1:0] g;
    unique case (d)
      5'd0:    g = 17'd65536;
      5'd1:    g = 17'd65209;
      5'd2:    g = 17'd64238;
      5'd3:    g = 17'd62652;
      5'd4:    g = 17'd60497;
      5'd5:    g = 17'd57835;
      5'd6:    g = 17'd54740;
      5'd7:    g = 17'd51295;
      5'd8:    g = 17'd47589;
      5'd9:    g = 17'd43711;
      5'd10:   g = 17'd39750;
      5'd11:   g = 17'd35788;
      5'd12:   g = 17'd31900;
      5'd13:   g = 17'd28151;
      5'd14:   g = 17'd24596;
      5'd15:   g = 17'd21276;
      5'd16:   g = 17'd18221;
      5'd17:   g = 17'd15450;
      5'd18:   g = 17'd12969;
      5'd19:   g = 17'd10779;
      5'd20:   g = 17'd8869;
      5'd21:   g = 17'd7225;
      5'd22:   g = 17'd5828;
      5'd23:   g = 17'd4653;
      5'd24:   g = 17'd3679;
      5'd25:   g = 17'd2879;
      5'd26:   g = 17'd2231;
      5'd27:   g = 17'd1712;
      5'd28:   g = 17'd1300;
      5'd29:   g = 17'd978;
      5'd30:   g = 17'd728;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/gsa_mac.sv]
module gsa_mac (
  input  logic                                 clk,
  input  gsa_pkg::gsa_mac_ctrl_t               ctrl,
  input  logic [gsa_pkg::WGT_W-1:0]            weight,
  input  logic [gsa_pkg::G_W-1:0]              gx,
  input  logic [gsa_pkg::G_W-1:0]              gy,
  input  logic signed [gsa_pkg::ACC_W-1:0]     rd_data,
  output logic signed [gsa_pkg::ACC_W-1:0]     wr_data
);

  localparam int WIDE_W = gsa_pkg::ACC_W + 2;

  logic [gsa_pkg::WGT_W-1:0]  a_r;
  logic [gsa_pkg::WGT_W-1:0]  amt_r;
  logic [gsa_pkg::WGT_W-1:0]  op_l;
  logic [gsa_pkg::G_W-1:0]    op_r;
  logic [gsa_pkg::PROD_W-1:0] prod;
  logic [gsa_pkg::PROD_W-1:0] prod_rnd;
  logic [gsa_pkg::WGT_W-1:0]  rnd_q;
  logic signed [WIDE_W-1:0]   wide;
  logic                       sub_q;

  // Shared multiplier: weight*G(dx) first, then that product*G(dy)
  assign op_l     = ctrl.load_amt ? a_r : weight;
  assign op_r     = ctrl.load_amt ? gy : gx;
  assign prod     = gsa_pkg::PROD_W'(op_l) * gsa_pkg::PROD_W'(op_r);
  // Round half up and drop 16 fraction bits; never exceeds the left operand
  assign prod_rnd = prod + gsa_pkg::PROD_W'(32768);
  assign rnd_q    = prod_rnd[16 +: gsa_pkg::WGT_W];

  always_ff @(posedge clk) begin
    if (ctrl.load_a) begin
      a_r <= rnd_q;
    end
    if (ctrl.load_amt) begin
      amt_r <= rnd_q;
      sub_q <= ctrl.sub;
    end
  end

  // Saturating read-modify-write of the cell
  always_comb begin
    if (sub_q) begin
      wide = WIDE_W'(rd_data) - $signed({{(WIDE_W-gsa_pkg::WGT_W){1'b0}}, amt_r});
    end else begin
      wide = WIDE_W'(rd_data) + $signed({{(WIDE_W-gsa_pkg::WGT_W){1'b0}}, amt_r});
    end
    if (wide[WIDE_W-1:gsa_pkg::ACC_W-1] == '0 || wide[WIDE_W-1:gsa_pkg::ACC_W-1] == '1) begin
      wr_data = wide[gsa_pkg::ACC_W-1:0];
    end else if (!wide[WIDE_W-1]) begin
      wr_data = gsa_pkg::ACC_MAX;
    end else begin
      wr_data = gsa_pkg::ACC_MIN;
    end
  end

endmodule

[rtl/core/gaussian_splat_accumulator.sv]
// Splat (add or subtract): the 61x61 window is walked one cell at a time, each cell
//   through states MULA and MULB, which share the one multiplier; busy holds off new requests.
// Probe: the request passes SETUP and PRD to the result strobe in DONE; the next request is taken in the cycle after.
// The result strobe lasts one cycle; the receiver cannot stall it.
// After reset the cell memory is swept to zero, one cell a cycle over all 409600 cells,
//   with busy high throughout.
module gaussian_splat_accumulator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gsa_pkg::gsa_in_t  in_req,
  output logic              out_valid,
  output gsa_pkg::gsa_out_t out_rsp
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_MULA  = 3'd3;
  localparam logic [2:0] ST_MULB  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_PRD   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam int AW = gsa_pkg::ADDR_W;
  localparam int SW = gsa_pkg::SADDR_W;
  localparam int CRW = gsa_pkg::COORD_W;
  localparam int NW = gsa_pkg::CNT_W;

  logic [2:0]                        state_r, state_nxt;
  logic [AW-1:0]                     clr_r, clr_nxt;
  gsa_pkg::gsa_in_t                  req_r, req_nxt;
  logic signed [CRW-1:0]             x_r, x_nxt;
  logic signed [CRW-1:0]             y_r, y_nxt;
  logic signed [CRW-1:0]             x0_r, x0_nxt;
  logic signed [SW-1:0]              addr_r, addr_nxt;
  logic [AW-1:0]                     waddr_r, waddr_nxt;
  logic [NW-1:0]                     dx_r, dx_nxt;
  logic [NW-1:0]                     dy_r, dy_nxt;
  logic                              pend_r, pend_nxt;
  logic                              ok_r, ok_nxt;
  logic                              is_probe_r, is_probe_nxt;

  logic signed [gsa_pkg::ACC_W-1:0]  cell_mem [0:gsa_pkg::TOTAL_CELLS-1];
  logic signed [gsa_pkg::ACC_W-1:0]  rd_r;
  logic                              mem_we;
  logic                              mem_re;
  logic [AW-1:0]                     mem_waddr;
  logic signed [gsa_pkg::ACC_W-1:0]  mem_wdata;
  logic signed [gsa_pkg::ACC_W-1:0]  mac_wdata;

  logic                              accept;
  logic                              cell_ok;
  logic                              last_pos;
  logic [gsa_pkg::GIDX_W-1:0]        gx_idx;
  logic [gsa_pkg::GIDX_W-1:0]        gy_idx;
  logic [gsa_pkg::G_W-1:0]           gx;
  logic [gsa_pkg::G_W-1:0]           gy;
  logic signed [CRW-1:0]             cx_in;
  logic signed [CRW-1:0]             cy_in;
  logic signed [SW-1:0]              cw_term;
  logic signed [SW-1:0]              row_term;
  gsa_pkg::gsa_mac_ctrl_t            mac_ctrl;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = (state_r == ST_DONE);

  assign out_rsp.in_bounds  = out_valid && ok_r;
  assign out_rsp.cell_value = (out_valid && ok_r) ? rd_r : '0;

  // Current window cell lies inside the map; row 0 and column 0 count as outside
  assign cell_ok = (x_r > 0) && (y_r > 0) &&
                   (x_r < CRW'(gsa_pkg::MAP_SIDE)) && (y_r < CRW'(gsa_pkg::MAP_SIDE));

  assign last_pos = (dx_r == NW'(gsa_pkg::WIN - 1)) && (dy_r == NW'(gsa_pkg::WIN - 1));

  // Kernel taps by distance from the window centre
  assign gx_idx = (dx_r < NW'(gsa_pkg::RADIUS)) ?
                  gsa_pkg::GIDX_W'(NW'(gsa_pkg::RADIUS) - dx_r) :
                  gsa_pkg::GIDX_W'(dx_r - NW'(gsa_pkg::RADIUS));
  assign gy_idx = (dy_r < NW'(gsa_pkg::RADIUS)) ?
                  gsa_pkg::GIDX_W'(NW'(gsa_pkg::RADIUS) - dy_r) :
                  gsa_pkg::GIDX_W'(dy_r - NW'(gsa_pkg::RADIUS));
  assign gx = gsa_pkg::gauss_lut(gx_idx);
  assign gy = gsa_pkg::gauss_lut(gy_idx);

  // Map centre plus offset
  assign cx_in = CRW'(gsa_pkg::MAP_SIDE / 2) + CRW'(in_req.x_offset);
  assign cy_in = CRW'(gsa_pkg::MAP_SIDE / 2) + CRW'(in_req.y_offset);

  // Linear cell address of (x_r, y_r) in the addressed map
  assign cw_term  = SW'(req_r.codeword) * SW'(gsa_pkg::CELLS_PER_MAP);
  assign row_term = SW'(y_r) * SW'(gsa_pkg::MAP_SIDE);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    req_nxt      = req_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    x0_nxt       = x0_r;
    addr_nxt     = addr_r;
    waddr_nxt    = waddr_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    pend_nxt     = pend_r;
    ok_nxt       = ok_r;
    is_probe_nxt = is_probe_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(gsa_pkg::TOTAL_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt      = in_req;
          ok_nxt       = 1'b0;
          pend_nxt     = 1'b0;
          dx_nxt       = '0;
          dy_nxt       = '0;
          is_probe_nxt = (in_req.command == gsa_pkg::CMD_PROBE);
          if (32'(in_req.codeword) >= 32'(gsa_pkg::CODEWORDS)) begin
            state_nxt = ST_DONE;
          end else begin
            case (in_req.command) inside
              gsa_pkg::CMD_ADD, gsa_pkg::CMD_SUB: begin
                x_nxt     = cx_in - CRW'(gsa_pkg::RADIUS);
                x0_nxt    = cx_in - CRW'(gsa_pkg::RADIUS);
                y_nxt     = cy_in - CRW'(gsa_pkg::RADIUS);
                state_nxt = ST_SETUP;
              end
              gsa_pkg::CMD_PROBE: begin
                x_nxt     = cx_in;
                x0_nxt    = cx_in;
                y_nxt     = cy_in;
                state_nxt = ST_SETUP;
              end
              default: begin
                state_nxt = ST_DONE;
              end
            endcase
          end
        end
      end
      ST_SETUP: begin
        addr_nxt  = cw_term + row_term + SW'(x_r);
        state_nxt = is_probe_r ? ST_PRD : ST_MULA;
      end
      ST_MULA: begin
        // retire the previous cell, read this one
        pend_nxt  = cell_ok;
        waddr_nxt = addr_r[AW-1:0];
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        if (last_pos) begin
          state_nxt = ST_FLUSH;
        end else if (dx_r == NW'(gsa_pkg::WIN - 1)) begin
          dx_nxt    = '0;
          dy_nxt    = dy_r + NW'(1);
          x_nxt     = x0_r;
          y_nxt     = y_r + CRW'(1);
          addr_nxt  = addr_r + SW'(gsa_pkg::ROW_STEP);
          state_nxt = ST_MULA;
        end else begin
          dx_nxt    = dx_r + NW'(1);
          x_nxt     = x_r + CRW'(1);
          addr_nxt  = addr_r + SW'(1);
          state_nxt = ST_MULA;
        end
      end
      ST_FLUSH: begin
        pend_nxt  = 1'b0;
        state_nxt = ST_DONE;
      end
      ST_PRD: begin
        ok_nxt    = cell_ok;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      pend_r     <= 1'b0;
      ok_r       <= 1'b0;
      is_probe_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      pend_r     <= pend_nxt;
      ok_r       <= ok_nxt;
      is_probe_r <= is_probe_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    x0_r    <= x0_nxt;
    addr_r  <= addr_nxt;
    waddr_r <= waddr_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
  end

  // Multiply/accumulate unit
  assign mac_ctrl.load_a   = (state_r == ST_MULA);
  assign mac_ctrl.load_amt = (state_r == ST_MULB);
  assign mac_ctrl.sub      = (req_r.command == gsa_pkg::CMD_SUB);

  gsa_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .weight  (req_r.weight),
    .gx      (gx),
    .gy      (gy),
    .rd_data (rd_r),
    .wr_data (mac_wdata)
  );

  // Cell memory: one write port, one registered read port
  assign mem_we    = (state_r == ST_CLEAR) ||
                     (((state_r == ST_MULA) || (state_r == ST_FLUSH)) && pend_r);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_r : waddr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : mac_wdata;
  assign mem_re    = ((state_r == ST_MULA) || (state_r == ST_PRD)) && cell_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= cell_mem[addr_r[AW-1:0]];
    end
  end

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after taking a request");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("cell memory written while idle");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.in_bounds) |-> (out_rsp.cell_value == '0))
    else $error("non-zero value on an out-of-bounds or splat result");

endmodule
